[design/assert_macros.svh]
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is masked while reset is high
`define ASSERT_RUN(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers the reset cycles
`define ASSERT_ANY(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/scfla_pkg.sv]
package scfla_pkg;

  localparam int PAGE_BYTES_DEF  = 4096;
  localparam int PAGE_COUNT_DEF  = 16;
  localparam int CLASS_COUNT_DEF = 10;

  localparam int ADDR_W      = 16;
  localparam int WORD_W      = 13;
  localparam int PTR_W       = 14;
  localparam int CNT_W       = 14;
  localparam int CLS_FIELD_W = 4;
  localparam int CFG_W       = 5;
  localparam int STORE_DEPTH = 8192;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic                REG_PAGES_AVAILABLE = 1'b0;
  localparam logic [CFG_W-1:0]    PAGES_AVAILABLE_RST = CFG_W'(16);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic                   command;
    logic [CLS_FIELD_W-1:0] class_id;
    logic [ADDR_W-1:0]      block_address;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] result_address;
    logic [CNT_W-1:0]  class_free_count;
    logic [CNT_W-1:0]  class_total_count;
  } out_item_t;

  typedef struct packed {
    logic cap;
    logic do_zero;
    logic do_free;
    logic do_fail;
    logic pop_read;
    logic pop_done;
    logic carve_start;
    logic carve_step;
    logic carve_done;
  } dp_cmd_t;

  typedef struct packed {
    logic class_ok;
    logic is_free;
    logic head_valid;
    logic page_left;
    logic carve_end;
  } dp_status_t;

endpackage

[design/scfla_ctrl.sv]
module scfla_ctrl
  import scfla_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_CARVE
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;
  logic   finish;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    finish     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.class_ok && !status.is_free && status.head_valid) begin
          cmd.pop_read = 1'b1;
          state_next   = S_POP;
        end else if (status.class_ok && !status.is_free && status.page_left) begin
          cmd.carve_start = 1'b1;
          state_next      = S_CARVE;
        end else if (slot_free) begin
          finish     = 1'b1;
          state_next = S_IDLE;
          if (!status.class_ok) begin
            cmd.do_zero = 1'b1;
          end else if (status.is_free) begin
            cmd.do_free = 1'b1;
          end else begin
            cmd.do_fail = 1'b1;
          end
        end
      end
      S_POP: begin
        if (slot_free) begin
          cmd.pop_done = 1'b1;
          finish       = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_CARVE: begin
        if (!status.carve_end) begin
          cmd.carve_step = 1'b1;
        end else if (slot_free) begin
          cmd.carve_done = 1'b1;
          finish         = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/scfla_dp.sv]
module scfla_dp
  import scfla_pkg::*;
#(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_status_t       status,
  input  in_item_t         in_data,
  input  logic [CFG_W-1:0] pages_available,
  output out_item_t        out_data
);

  localparam int CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int PU_W      = $clog2(PAGE_COUNT + 1);
  localparam int LIM_W     = (PU_W > CFG_W) ? PU_W : CFG_W;
  localparam int MAX_BLOCK = 8 << (CLASS_COUNT - 1);
  localparam int OFF_W     = $clog2(PAGE_BYTES + MAX_BLOCK) + 1;
  localparam int WPP       = PAGE_BYTES / 8;
  localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(PAGE_BYTES);

  in_item_t          req;
  logic [PTR_W-1:0]  heads [CLASS_COUNT];
  logic [CNT_W-1:0]  free_cnt [CLASS_COUNT];
  logic [CNT_W-1:0]  total_cnt [CLASS_COUNT];
  logic [PU_W-1:0]   pages_used;
  logic [ADDR_W-1:0] page_base;
  logic [OFF_W-1:0]  off;
  logic [PTR_W-1:0]  last;
  logic [PTR_W-1:0]  rdata;
  logic [PTR_W-1:0]  store [STORE_DEPTH];

  logic [CLS_W-1:0]  cls_idx;
  logic [PTR_W-1:0]  head;
  logic [WORD_W-1:0] head_w;
  logic [WORD_W-1:0] req_w;
  logic [ADDR_W-1:0] carve_addr;
  logic [WORD_W-1:0] carve_w;
  logic [OFF_W-1:0]  block_size;
  logic [CNT_W-1:0]  ent_raw;
  logic [CNT_W-1:0]  entries;
  logic [CNT_W-1:0]  free_cur;
  logic [CNT_W-1:0]  total_cur;
  logic [CNT_W-1:0]  free_next;
  logic [CNT_W-1:0]  total_next;
  logic              store_we;
  logic [WORD_W-1:0] store_waddr;
  logic [PTR_W-1:0]  store_wdata;
  out_item_t         res;

  assign cls_idx    = req.class_id[CLS_W-1:0];
  assign head       = heads[cls_idx];
  assign head_w     = head[WORD_W-1:0];
  assign free_cur   = free_cnt[cls_idx];
  assign total_cur  = total_cnt[cls_idx];
  assign req_w      = req.block_address[ADDR_W-1:3];
  assign carve_addr = page_base + ADDR_W'(off);
  assign carve_w    = carve_addr[ADDR_W-1:3];
  assign block_size = OFF_W'(8) << req.class_id;
  assign ent_raw    = CNT_W'(WPP) >> req.class_id;
  assign entries    = (ent_raw == '0) ? CNT_W'(1) : ent_raw;

  assign status.class_ok   = req.class_id < CLS_FIELD_W'(CLASS_COUNT);
  assign status.is_free    = (req.command == CMD_FREE);
  assign status.head_valid = head[PTR_W-1];
  assign status.page_left  = (LIM_W'(pages_used) < LIM_W'(pages_available)) &&
                             (pages_used < PU_W'(PAGE_COUNT));
  assign status.carve_end  = (off >= OFF_W'(PAGE_BYTES));

  assign store_we    = cmd.do_free || cmd.carve_step;
  assign store_waddr = cmd.do_free ? req_w : carve_w;
  assign store_wdata = cmd.do_free ? head : last;

  always_comb begin
    free_next  = free_cur;
    total_next = total_cur;
    res        = '0;
    if (cmd.do_free) begin
      free_next = free_cur + CNT_W'(1);
    end else if (cmd.pop_done) begin
      free_next = free_cur - CNT_W'(1);
    end else if (cmd.carve_done) begin
      free_next  = free_cur + entries - CNT_W'(1);
      total_next = total_cur + entries;
    end
    if (!cmd.do_zero) begin
      res.ok                = !cmd.do_fail;
      res.class_free_count  = free_next;
      res.class_total_count = total_next;
      if (cmd.pop_done) begin
        res.result_address = {head_w, 3'b000};
      end else if (cmd.carve_done) begin
        res.result_address = page_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CLASS_COUNT; i++) begin
        heads[i]     <= '0;
        free_cnt[i]  <= '0;
        total_cnt[i] <= '0;
      end
      pages_used <= '0;
      page_base  <= '0;
    end else begin
      if (cmd.do_free) begin
        heads[cls_idx]    <= {1'b1, req_w};
        free_cnt[cls_idx] <= free_next;
      end
      if (cmd.pop_done) begin
        heads[cls_idx]    <= rdata;
        free_cnt[cls_idx] <= free_next;
      end
      if (cmd.carve_done) begin
        heads[cls_idx]     <= last;
        free_cnt[cls_idx]  <= free_next;
        total_cnt[cls_idx] <= total_next;
        pages_used         <= pages_used + PU_W'(1);
        page_base          <= page_base + PAGE_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req <= in_data;
    end
    if (cmd.carve_start) begin
      off  <= block_size;
      last <= '0;
    end else if (cmd.carve_step) begin
      off  <= off + block_size;
      last <= {1'b1, carve_w};
    end
    if (cmd.do_zero || cmd.do_free || cmd.do_fail || cmd.pop_done || cmd.carve_done) begin
      out_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store[store_waddr] <= store_wdata;
    end
    if (cmd.pop_read) begin
      rdata <= store[head_w];
    end
  end

endmodule

[design/size_class_free_list_allocator.sv]
// Channel   Direction  Handshake             Payload
// config    in         psel/penable/pready   pwdata, paddr, prdata (pages_available)
// request   in         in_valid / in_stall   in_data (command, class_id, block_address)
// result    out        out_valid / out_stall out_data (ok, address, free and total counts)
//
// One request at a time. Free, failed or out-of-range requests finish in the execute state;
// an allocate from a non-empty list adds one read of the next-pointer RAM.
// An allocate that carves a page writes the next-pointer RAM once per carved block after the
// first, which is returned; no write is made when a block is no smaller than a page.
// Synchronous reset empties all lists and counts; the pointer RAM is not cleared.
// A stalled result holds its register; the next request is taken meanwhile.
module size_class_free_list_allocator
  import scfla_pkg::*;
#(
  parameter int PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  logic [CFG_W-1:0] pages_available;
  dp_cmd_t          cmd;
  dp_status_t       status;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PAGES_AVAILABLE) ?
                  APB_DATA_W'(pages_available) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_available <= PAGES_AVAILABLE_RST;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_PAGES_AVAILABLE)) begin
      pages_available <= pwdata[CFG_W-1:0];
    end
  end

  scfla_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  scfla_dp #(
    .PAGE_BYTES  (PAGE_BYTES),
    .PAGE_COUNT  (PAGE_COUNT),
    .CLASS_COUNT (CLASS_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .in_data         (in_data),
    .pages_available (pages_available),
    .out_data        (out_data)
  );

endmodule

[design/scfla_checker.sv]
`include "assert_macros.svh"

module scfla_checker
  import scfla_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  `ASSERT_ANY(a_rst_clears_out, clk, rst |=> !out_valid, "result valid after reset")
  `ASSERT_RUN(a_one_request, clk, rst, in_valid && !in_stall |=> in_stall, "second request taken while busy")
  `ASSERT_RUN(a_fail_addr_zero, clk, rst, out_valid && !out_data.ok |-> out_data.result_address == '0, "failed result carries an address")
  `ASSERT_RUN(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")

endmodule

bind size_class_free_list_allocator scfla_checker u_scfla_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
